>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

// A stalled transfer keeps valid high and its data stable.
`define ASSERT_HOLD(label, clk, rst, valid, ready, data) \
  label: assert property (@(posedge clk) disable iff (rst) \
    ((valid) && !(ready)) |=> ((valid) && $stable(data))) \
    else $error("assertion failed (stalled data moved)");

`endif

>>> hdl/cpu65_pkg.sv
// Package: operation codes, flag positions and register-file type of the execute unit.
`timescale 1ns / 1ps
`default_nettype none

package cpu65_pkg;

  typedef enum logic [5:0] {
    OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
    OP_STX = 6'd4,  OP_STY = 6'd5,  OP_TAX = 6'd6,  OP_TAY = 6'd7,
    OP_TXA = 6'd8,  OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11,
    OP_PHA = 6'd12, OP_PHP = 6'd13, OP_PLA = 6'd14, OP_PLP = 6'd15,
    OP_AND = 6'd16, OP_EOR = 6'd17, OP_ORA = 6'd18, OP_BIT = 6'd19,
    OP_ADC = 6'd20, OP_SBC = 6'd21, OP_CMP = 6'd22, OP_CPX = 6'd23,
    OP_CPY = 6'd24, OP_INC = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27,
    OP_DEC = 6'd28, OP_DEX = 6'd29, OP_DEY = 6'd30, OP_ASL = 6'd31,
    OP_LSR = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34, OP_CLC = 6'd35,
    OP_CLD = 6'd36, OP_CLI = 6'd37, OP_CLV = 6'd38, OP_SEC = 6'd39,
    OP_SED = 6'd40, OP_SEI = 6'd41, OP_NOP = 6'd42, OP_LAX = 6'd43,
    OP_SAX = 6'd44, OP_DCP = 6'd45, OP_ISC = 6'd46, OP_SLO = 6'd47,
    OP_RLA = 6'd48, OP_SRE = 6'd49, OP_RRA = 6'd50
  } op_t;

  // Bit positions in the status byte NV-BDIZC
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0] SP_RESET     = 8'hFD;
  localparam logic [7:0] STATUS_RESET = 8'h24;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_data;
    logic [7:0] slot;
  } mem_req_t;

endpackage

`default_nettype wire

>>> hdl/cpu65_alu.sv
// Combinational execute logic: next register file and memory write for one operation.
`timescale 1ns / 1ps
`default_nettype none

module cpu65_alu (
  input  wire logic [5:0]       op,
  input  wire logic [7:0]       operand,
  input  wire cpu65_pkg::regs_t cur,
  output cpu65_pkg::regs_t      nxt,
  output cpu65_pkg::mem_req_t   req
);
  import cpu65_pkg::*;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[FLAG_Z] = (v == 8'd0);
    r[FLAG_N] = v[7];
    return r;
  endfunction

  // reg - m: carry set when reg >= m
  function automatic logic [7:0] cmp(input logic [7:0] p, input logic [7:0] r,
                                     input logic [7:0] m);
    logic [8:0] d;
    logic [7:0] q;
    d = {1'b0, r} + {1'b0, ~m} + 9'd1;
    q = p;
    q[FLAG_C] = d[8];
    return set_nz(q, d[7:0]);
  endfunction

  logic [7:0] m_inc, m_dec, asl_v, lsr_v, rol_v, ror_v;
  logic [7:0] add_b;
  logic       add_c;
  logic [8:0] sum;
  logic [7:0] p_add;

  always_comb begin
    m_inc = operand + 8'd1;
    m_dec = operand - 8'd1;
    asl_v = {operand[6:0], 1'b0};
    lsr_v = {1'b0, operand[7:1]};
    rol_v = {operand[6:0], cur.p[FLAG_C]};
    ror_v = {cur.p[FLAG_C], operand[7:1]};

    // Shared adder: subtraction adds the inverted byte; RRA takes the rotate carry
    case (op_t'(op))
      OP_SBC: begin
        add_b = ~operand;
        add_c = cur.p[FLAG_C];
      end
      OP_ISC: begin
        add_b = ~m_inc;
        add_c = cur.p[FLAG_C];
      end
      OP_RRA: begin
        add_b = ror_v;
        add_c = operand[0];
      end
      default: begin
        add_b = operand;
        add_c = cur.p[FLAG_C];
      end
    endcase
    sum = {1'b0, cur.a} + {1'b0, add_b} + {8'd0, add_c};
    p_add = cur.p;
    p_add[FLAG_C] = sum[8];
    p_add[FLAG_V] = ~(cur.a[7] ^ add_b[7]) & (cur.a[7] ^ sum[7]);
    p_add = set_nz(p_add, sum[7:0]);
  end

  always_comb begin
    nxt = cur;
    req = '0;
    case (op_t'(op))
      OP_LDA: begin
        nxt.a = operand;
        nxt.p = set_nz(cur.p, operand);
      end
      OP_LDX: begin
        nxt.x = operand;
        nxt.p = set_nz(cur.p, operand);
      end
      OP_LDY: begin
        nxt.y = operand;
        nxt.p = set_nz(cur.p, operand);
      end
      OP_STA: begin
        req.wr_en = 1'b1;
        req.wr_data = cur.a;
      end
      OP_STX: begin
        req.wr_en = 1'b1;
        req.wr_data = cur.x;
      end
      OP_STY: begin
        req.wr_en = 1'b1;
        req.wr_data = cur.y;
      end
      OP_TAX: begin
        nxt.x = cur.a;
        nxt.p = set_nz(cur.p, cur.a);
      end
      OP_TAY: begin
        nxt.y = cur.a;
        nxt.p = set_nz(cur.p, cur.a);
      end
      OP_TXA: begin
        nxt.a = cur.x;
        nxt.p = set_nz(cur.p, cur.x);
      end
      OP_TYA: begin
        nxt.a = cur.y;
        nxt.p = set_nz(cur.p, cur.y);
      end
      OP_TSX: begin
        nxt.x = cur.sp;
        nxt.p = set_nz(cur.p, cur.sp);
      end
      OP_TXS: nxt.sp = cur.x;
      OP_PHA: begin
        req.wr_en = 1'b1;
        req.wr_data = cur.a;
        req.slot = cur.sp;
        nxt.sp = cur.sp - 8'd1;
      end
      OP_PHP: begin
        req.wr_en = 1'b1;
        req.wr_data = cur.p | 8'h30;
        req.slot = cur.sp;
        nxt.sp = cur.sp - 8'd1;
      end
      OP_PLA: begin
        nxt.sp = cur.sp + 8'd1;
        req.slot = cur.sp + 8'd1;
        nxt.a = operand;
        nxt.p = set_nz(cur.p, operand);
      end
      OP_PLP: begin
        nxt.sp = cur.sp + 8'd1;
        req.slot = cur.sp + 8'd1;
        nxt.p = operand;
        nxt.p[FLAG_B] = 1'b0;
        nxt.p[FLAG_U] = 1'b1;
      end
      OP_AND: begin
        nxt.a = cur.a & operand;
        nxt.p = set_nz(cur.p, cur.a & operand);
      end
      OP_EOR: begin
        nxt.a = cur.a ^ operand;
        nxt.p = set_nz(cur.p, cur.a ^ operand);
      end
      OP_ORA: begin
        nxt.a = cur.a | operand;
        nxt.p = set_nz(cur.p, cur.a | operand);
      end
      OP_BIT: begin
        nxt.p[FLAG_Z] = ((cur.a & operand) == 8'd0);
        nxt.p[FLAG_V] = operand[6];
        nxt.p[FLAG_N] = operand[7];
      end
      OP_ADC, OP_SBC: begin
        nxt.a = sum[7:0];
        nxt.p = p_add;
      end
      OP_CMP: nxt.p = cmp(cur.p, cur.a, operand);
      OP_CPX: nxt.p = cmp(cur.p, cur.x, operand);
      OP_CPY: nxt.p = cmp(cur.p, cur.y, operand);
      OP_INC: begin
        req.wr_en = 1'b1;
        req.wr_data = m_inc;
        nxt.p = set_nz(cur.p, m_inc);
      end
      OP_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.p = set_nz(cur.p, cur.x + 8'd1);
      end
      OP_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.p = set_nz(cur.p, cur.y + 8'd1);
      end
      OP_DEC: begin
        req.wr_en = 1'b1;
        req.wr_data = m_dec;
        nxt.p = set_nz(cur.p, m_dec);
      end
      OP_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.p = set_nz(cur.p, cur.x - 8'd1);
      end
      OP_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.p = set_nz(cur.p, cur.y - 8'd1);
      end
      OP_ASL: begin
        req.wr_en = 1'b1;
        req.wr_data = asl_v;
        nxt.p = set_nz(cur.p, asl_v);
        nxt.p[FLAG_C] = operand[7];
      end
      OP_LSR: begin
        req.wr_en = 1'b1;
        req.wr_data = lsr_v;
        nxt.p = set_nz(cur.p, lsr_v);
        nxt.p[FLAG_C] = operand[0];
      end
      OP_ROL: begin
        req.wr_en = 1'b1;
        req.wr_data = rol_v;
        nxt.p = set_nz(cur.p, rol_v);
        nxt.p[FLAG_C] = operand[7];
      end
      OP_ROR: begin
        req.wr_en = 1'b1;
        req.wr_data = ror_v;
        nxt.p = set_nz(cur.p, ror_v);
        nxt.p[FLAG_C] = operand[0];
      end
      OP_CLC: nxt.p[FLAG_C] = 1'b0;
      OP_CLD: nxt.p[FLAG_D] = 1'b0;
      OP_CLI: nxt.p[FLAG_I] = 1'b0;
      OP_CLV: nxt.p[FLAG_V] = 1'b0;
      OP_SEC: nxt.p[FLAG_C] = 1'b1;
      OP_SED: nxt.p[FLAG_D] = 1'b1;
      OP_SEI: nxt.p[FLAG_I] = 1'b1;
      OP_LAX: begin
        nxt.a = operand;
        nxt.x = operand;
        nxt.p = set_nz(cur.p, operand);
      end
      OP_SAX: begin
        req.wr_en = 1'b1;
        req.wr_data = cur.a & cur.x;
      end
      OP_DCP: begin
        req.wr_en = 1'b1;
        req.wr_data = m_dec;
        nxt.p = cmp(cur.p, cur.a, m_dec);
      end
      OP_ISC: begin
        req.wr_en = 1'b1;
        req.wr_data = m_inc;
        nxt.a = sum[7:0];
        nxt.p = p_add;
      end
      OP_SLO: begin
        req.wr_en = 1'b1;
        req.wr_data = asl_v;
        nxt.a = cur.a | asl_v;
        nxt.p = set_nz(cur.p, cur.a | asl_v);
        nxt.p[FLAG_C] = operand[7];
      end
      OP_RLA: begin
        req.wr_en = 1'b1;
        req.wr_data = rol_v;
        nxt.a = cur.a & rol_v;
        nxt.p = set_nz(cur.p, cur.a & rol_v);
        nxt.p[FLAG_C] = operand[7];
      end
      OP_SRE: begin
        req.wr_en = 1'b1;
        req.wr_data = lsr_v;
        nxt.a = cur.a ^ lsr_v;
        nxt.p = set_nz(cur.p, cur.a ^ lsr_v);
        nxt.p[FLAG_C] = operand[0];
      end
      OP_RRA: begin
        req.wr_en = 1'b1;
        req.wr_data = ror_v;
        nxt.a = sum[7:0];
        nxt.p = p_add;
      end
      default: ; // NOP and undefined codes leave everything as is
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/cpu6502_execute_unit.sv
// Top level: input stage, register file and result register of the 6502 execute unit.
//
// Usage:
//   Input channel s_axis_*: one 6502 data operation per transfer, opcode in
//   tdata[5:0] and the memory (or popped) byte in tdata[13:6].
//   Output channel m_axis_*: exactly one result per input, in order. tuser is
//   the memory write enable; tdata carries write byte, stack slot and the
//   A, X, Y, S and P registers after the operation.
//   Path: an input transfer is captured in the input register, then executed
//   into the result register, which drives m_axis_tvalid and m_axis_tdata.
//   Throughput: one operation per cycle unless the output stalls; the
//   register file is updated in the execute cycle, so back-to-back
//   operations see each other's results.
//   Reset (rst, synchronous): both stages empty, A=X=Y=0, S=0xFD, P=0x24.
//   Stall: when m_axis_tready is low the result register holds; one more
//   operation waits in the input register, after which s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module cpu6502_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // operation[5:0], operand[13:6], zero[15:14]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [55:0] m_axis_tdata,  // write_data, stack_slot, acc_out, x_out, y_out,
                                          // sp_out, status_out (8 bits each, low first)
  output      logic [0:0]  m_axis_tuser   // write_enable
);
  import cpu65_pkg::*;

  logic       in_valid;
  logic [5:0] in_op;
  logic [7:0] in_operand;
  logic       exec;

  regs_t      regs;
  regs_t      regs_next;
  mem_req_t   req;

  assign exec          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || exec;

  cpu65_alu u_alu (
    .op      (in_op),
    .operand (in_operand),
    .cur     (regs),
    .nxt     (regs_next),
    .req     (req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op      <= s_axis_tdata[5:0];
      in_operand <= s_axis_tdata[13:6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.a  <= 8'd0;
      regs.x  <= 8'd0;
      regs.y  <= 8'd0;
      regs.sp <= SP_RESET;
      regs.p  <= STATUS_RESET;
    end else if (exec) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      m_axis_tuser <= req.wr_en;
      m_axis_tdata <= {regs_next.p, regs_next.sp, regs_next.y, regs_next.x,
                       regs_next.a, req.slot, req.wr_data};
    end
  end

endmodule

`default_nettype wire

>>> hdl/cpu65_checker.sv
// Port-level checker for the execute unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cpu65_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [15:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // A stalled operation keeps its payload until the transfer
  `ASSERT_HOLD(a_in_hold, clk, rst, s_axis_tvalid, s_axis_tready, s_axis_tdata)

  // A stalled result keeps its payload
  `ASSERT_HOLD(a_out_hold, clk, rst, m_axis_tvalid, m_axis_tready, {m_axis_tuser, m_axis_tdata})

  // Status always shows the unused bit set and the break bit clear
  `ASSERT_SAME(a_status_bits, clk, rst, m_axis_tvalid, m_axis_tdata[53] && !m_axis_tdata[52])

  // No write means a zero write byte
  `ASSERT_SAME(a_no_write_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[7:0] == 8'd0)

  // Reset empties the output stage
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid)

endmodule

bind cpu6502_execute_unit cpu65_checker u_cpu65_checker (.*);

`default_nettype wire
